// ----- hdl/ccr_pkg.sv -----
package ccr_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_VOLT_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CURR_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VOLT_TARGET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CURR_TARGET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_FLOOR  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_PERIOD = 3'd5;

  localparam logic [7:0] RST_VOLT_GAIN   = 8'd100;
  localparam logic [7:0] RST_CURR_GAIN   = 8'd10;
  localparam logic [9:0] RST_VOLT_TARGET = 10'd285;
  localparam logic [9:0] RST_CURR_TARGET = 10'd50;
  localparam logic [9:0] RST_DUTY_FLOOR  = 10'd230;
  localparam logic [9:0] RST_DUTY_PERIOD = 10'd400;

  localparam logic [9:0] LEVEL_MAX      = 10'd999;
  localparam logic [9:0] LOW_CURR_FLOOR = 10'd280;
  localparam logic [9:0] LOW_CURR_LIMIT = 10'd30;
  localparam logic [9:0] BIG_ERROR      = 10'd16;

  typedef struct packed {
    logic [7:0] volt_gain;
    logic [7:0] curr_gain;
    logic [9:0] volt_target;
    logic [9:0] curr_target;
    logic [9:0] duty_floor;
    logic [9:0] duty_period;
  } cfg_t;

endpackage

// ----- hdl/ccr_cfg.sv -----
module ccr_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ccr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ccr_pkg::CFG_DATA_W-1:0] cfg_data,
  output ccr_pkg::cfg_t                 cfg_o
);
  import ccr_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg_o     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_VOLT_GAIN:   cfg_nxt.volt_gain   = cfg_data[7:0];
        REG_CURR_GAIN:   cfg_nxt.curr_gain   = cfg_data[7:0];
        REG_VOLT_TARGET: cfg_nxt.volt_target = cfg_data;
        REG_CURR_TARGET: cfg_nxt.curr_target = cfg_data;
        REG_DUTY_FLOOR:  cfg_nxt.duty_floor  = cfg_data;
        REG_DUTY_PERIOD: cfg_nxt.duty_period = cfg_data;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.volt_gain   <= RST_VOLT_GAIN;
      cfg_r.curr_gain   <= RST_CURR_GAIN;
      cfg_r.volt_target <= RST_VOLT_TARGET;
      cfg_r.curr_target <= RST_CURR_TARGET;
      cfg_r.duty_floor  <= RST_DUTY_FLOOR;
      cfg_r.duty_period <= RST_DUTY_PERIOD;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- hdl/ccr_level.sv -----
module ccr_level (
  input  logic          clk,
  input  logic          rst_n,
  input  ccr_pkg::cfg_t cfg_i,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [15:0]   in_volt_sum,
  input  logic [15:0]   in_curr_sum,
  output logic          lvl_valid,
  input  logic          lvl_ready,
  output logic [9:0]    lvl_volt,
  output logic [9:0]    lvl_curr
);
  import ccr_pkg::*;

  logic        a_valid_r, a_valid_nxt;
  logic [15:0] volt_sum_r, curr_sum_r;
  logic        b_valid_r, b_valid_nxt;
  logic [9:0]  volt_lvl_r, curr_lvl_r;
  logic        a_ready, b_ready;

  logic [8:0]  v;
  logic [7:0]  c;
  logic [16:0] vprod;
  logic [15:0] cprod;
  logic [10:0] vraw, craw;
  logic [9:0]  vl_nxt, cl_nxt;

  assign b_ready  = !b_valid_r || lvl_ready;
  assign a_ready  = !a_valid_r || b_ready;
  assign in_ready = a_ready;

  assign a_valid_nxt = a_ready ? in_valid : a_valid_r;
  assign b_valid_nxt = b_ready ? a_valid_r : b_valid_r;

  // level = base + base*gain/256 (current also adds base/2), products at full width
  assign v     = volt_sum_r[15:7];
  assign c     = curr_sum_r[15:8];
  assign vprod = {8'd0, v} * {9'd0, cfg_i.volt_gain};
  assign cprod = {8'd0, c} * {8'd0, cfg_i.curr_gain};
  assign vraw  = {2'd0, v} + {2'd0, vprod[16:8]};
  assign craw  = {3'd0, c} + {4'd0, c[7:1]} + {3'd0, cprod[15:8]};
  assign vl_nxt = (vraw > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : vraw[9:0];
  assign cl_nxt = (craw > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : craw[9:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && a_ready) begin
      volt_sum_r <= in_volt_sum;
      curr_sum_r <= in_curr_sum;
    end
    if (a_valid_r && b_ready) begin
      volt_lvl_r <= vl_nxt;
      curr_lvl_r <= cl_nxt;
    end
  end

  assign lvl_valid = b_valid_r;
  assign lvl_volt  = volt_lvl_r;
  assign lvl_curr  = curr_lvl_r;

endmodule

// ----- hdl/ccr_regulate.sv -----
module ccr_regulate (
  input  logic          clk,
  input  logic          rst_n,
  input  ccr_pkg::cfg_t cfg_i,
  input  logic          lvl_valid,
  output logic          lvl_ready,
  input  logic [9:0]    lvl_volt,
  input  logic [9:0]    lvl_curr,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [9:0]    out_duty_out,
  output logic [9:0]    out_volt_level,
  output logic [9:0]    out_curr_level,
  output logic          out_cc_mode
);
  import ccr_pkg::*;

  logic        mode_r, mode_nxt;
  logic [10:0] duty_r, duty_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [9:0]  duty_out_r, volt_level_r, curr_level_r;
  logic        xfer;

  logic [10:0] vl_w, cl_w, vt_w, ct_w, floor_w, period_w, lo_w;
  logic        cv_up, cv_dn;
  logic [9:0]  err;
  logic [6:0]  step;
  logic [10:0] step_w, d_cc, d_cv, d_sel;

  assign xfer      = lvl_valid && lvl_ready;
  assign lvl_ready = !out_valid_r || out_ready;

  assign vl_w     = {1'b0, lvl_volt};
  assign cl_w     = {1'b0, lvl_curr};
  assign vt_w     = {1'b0, cfg_i.volt_target};
  assign ct_w     = {1'b0, cfg_i.curr_target};
  assign floor_w  = {1'b0, cfg_i.duty_floor};
  assign period_w = {1'b0, cfg_i.duty_period};

  // hysteresis: leave CC above vt+3, enter CC above ct+4
  assign mode_nxt = mode_r ? !(vl_w > vt_w + 11'd3) : (cl_w > ct_w + 11'd4);

  always_comb begin
    if (cl_w > ct_w + 11'd3) begin
      d_cc = duty_r + 11'd1;
    end else if (cl_w + 11'd2 < ct_w) begin
      d_cc = (duty_r > 11'd1) ? duty_r - 11'd1 : floor_w;
    end else begin
      d_cc = duty_r;
    end
  end

  assign cv_up  = vl_w > vt_w + 11'd2;
  assign cv_dn  = vl_w + 11'd2 < vt_w;
  assign err    = cv_up ? lvl_volt - cfg_i.volt_target : cfg_i.volt_target - lvl_volt;
  assign step   = (err >= BIG_ERROR) ? err[9:3] : 7'd1;
  assign step_w = {4'd0, step};

  always_comb begin
    if (cv_up) begin
      d_cv = duty_r + step_w;
    end else if (cv_dn) begin
      d_cv = (duty_r >= step_w) ? duty_r - step_w : floor_w;
    end else begin
      d_cv = duty_r;
    end
  end

  assign lo_w  = (!mode_nxt && (lvl_curr < LOW_CURR_LIMIT)) ? {1'b0, LOW_CURR_FLOOR} : floor_w;
  assign d_sel = mode_nxt ? d_cc : d_cv;

  always_comb begin
    if (d_sel > period_w) begin
      duty_nxt = period_w;
    end else if (d_sel < lo_w) begin
      duty_nxt = lo_w;
    end else begin
      duty_nxt = d_sel;
    end
  end

  assign out_valid_nxt = xfer ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      duty_r      <= {1'b0, RST_DUTY_PERIOD};
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (xfer) begin
        mode_r <= mode_nxt;
        duty_r <= duty_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      duty_out_r   <= duty_nxt[9:0];
      volt_level_r <= lvl_volt;
      curr_level_r <= lvl_curr;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_duty_out   = duty_out_r;
  assign out_volt_level = volt_level_r;
  assign out_curr_level = curr_level_r;
  assign out_cc_mode    = mode_r;

  a_duty_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    xfer |=> (duty_r <= $past(period_w)) || (duty_r == $past(lo_w)))
    else $error("duty outside clamp range");

  a_state_held: assert property (@(posedge clk) disable iff (!rst_n)
    !xfer |=> $stable(mode_r) && $stable(duty_r))
    else $error("regulator state moved without a transaction");

  a_cc_entry: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(mode_r) |-> $past(lvl_curr) > $past(cfg_i.curr_target))
    else $error("CC entered without current above target");

  a_result_match: assert property (@(posedge clk) disable iff (!rst_n)
    xfer |=> out_valid_r && (duty_out_r == duty_r[9:0]))
    else $error("result register out of step with duty state");

endmodule

// ----- hdl/cc_cv_duty_regulator.sv -----
// Channel  Handshake             Payload
// in       in_valid/in_ready     in_volt_sum[15:0], in_curr_sum[15:0]
// out      out_valid/out_ready   out_duty_out, out_volt_level, out_curr_level, out_cc_mode
// cfg      cfg_valid/cfg_ready   cfg_index[2:0], cfg_data[9:0]
//
// One transaction per cycle sustained while out_ready stays high; each result passes through
// the input register, level register and result register, in that order.
// Duty and mode state update in the same cycle as the result register loads.
// Synchronous active-low reset; cfg_ready is always high.
// Stalls on out back up stage by stage; in_ready stays high while any stage is empty.
module cc_cv_duty_regulator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [15:0]                   in_volt_sum,
  input  logic [15:0]                   in_curr_sum,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [9:0]                    out_duty_out,
  output logic [9:0]                    out_volt_level,
  output logic [9:0]                    out_curr_level,
  output logic                          out_cc_mode,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ccr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ccr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ccr_pkg::*;

  cfg_t       cfg;
  logic       lvl_valid, lvl_ready;
  logic [9:0] lvl_volt, lvl_curr;

  ccr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  ccr_level u_level (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_i       (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_volt_sum (in_volt_sum),
    .in_curr_sum (in_curr_sum),
    .lvl_valid   (lvl_valid),
    .lvl_ready   (lvl_ready),
    .lvl_volt    (lvl_volt),
    .lvl_curr    (lvl_curr)
  );

  ccr_regulate u_regulate (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_i          (cfg),
    .lvl_valid      (lvl_valid),
    .lvl_ready      (lvl_ready),
    .lvl_volt       (lvl_volt),
    .lvl_curr       (lvl_curr),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_duty_out   (out_duty_out),
    .out_volt_level (out_volt_level),
    .out_curr_level (out_curr_level),
    .out_cc_mode    (out_cc_mode)
  );

endmodule

// ----- dv/cc_cv_duty_regulator_checker.sv -----
module cc_cv_duty_regulator_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [15:0]                    in_volt_sum,
  input  logic [15:0]                    in_curr_sum,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [9:0]                     out_duty_out,
  input  logic [9:0]                     out_volt_level,
  input  logic [9:0]                     out_curr_level,
  input  logic                           out_cc_mode,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [ccr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ccr_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             awaiting
);
  import ccr_pkg::*;

  typedef struct packed {
    logic [9:0] duty;
    logic [9:0] volt_level;
    logic [9:0] curr_level;
    logic       cc_mode;
  } regulation_t;

  cfg_t        regs;
  logic [10:0] duty_state;
  logic        cc_state;
  regulation_t awaited_results[$];
  int          fails = 0;
  int          queued = 0;

  assign fail_count = fails;
  assign awaiting   = queued;

  // advances duty and mode state by one control step
  function automatic regulation_t regulate(input logic [15:0] volt_sum,
                                           input logic [15:0] curr_sum);
    logic [8:0]  v;
    logic [7:0]  c;
    logic [16:0] vprod;
    logic [15:0] cprod;
    logic [10:0] vsum;
    logic [10:0] csum;
    logic [9:0]  vl;
    logic [9:0]  cl;
    int          vli, cli, vt, ct, d, err, stp, lo;
    regulation_t r;
    v     = volt_sum[15:7];
    c     = curr_sum[15:8];
    vprod = v * regs.volt_gain;
    cprod = c * regs.curr_gain;
    vsum  = v + vprod[16:8];
    csum  = c + (c >> 1) + cprod[15:8];
    vl    = (vsum > LEVEL_MAX) ? LEVEL_MAX : vsum[9:0];
    cl    = (csum > LEVEL_MAX) ? LEVEL_MAX : csum[9:0];
    vli   = int'(vl);
    cli   = int'(cl);
    vt    = int'(regs.volt_target);
    ct    = int'(regs.curr_target);
    d     = int'(duty_state);

    if (cc_state) begin
      if (vli > vt + 3) cc_state = 1'b0;
    end else if (cli > ct + 4) begin
      cc_state = 1'b1;
    end

    if (cc_state) begin
      if (cli > ct + 3) d = d + 1;
      else if (cli + 2 < ct) d = (d > 1) ? d - 1 : int'(regs.duty_floor);
      lo = int'(regs.duty_floor);
    end else begin
      err = (vli > vt) ? vli - vt : vt - vli;
      stp = (err >= int'(BIG_ERROR)) ? (err >> 3) : 1;
      if (vli > vt + 2) d = d + stp;
      else if (vli + 2 < vt) d = (d >= stp) ? d - stp : int'(regs.duty_floor);
      lo = (cli < int'(LOW_CURR_LIMIT)) ? int'(LOW_CURR_FLOOR) : int'(regs.duty_floor);
    end

    if (d > int'(regs.duty_period)) d = int'(regs.duty_period);
    else if (d < lo) d = lo;

    duty_state   = 11'(d);
    r.duty       = duty_state[9:0];
    r.volt_level = vl;
    r.curr_level = cl;
    r.cc_mode    = cc_state;
    return r;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    regulation_t want;
    if (!rst_n) begin
      regs = '{RST_VOLT_GAIN, RST_CURR_GAIN, RST_VOLT_TARGET,
               RST_CURR_TARGET, RST_DUTY_FLOOR, RST_DUTY_PERIOD};
      duty_state = {1'b0, RST_DUTY_PERIOD};
      cc_state   = 1'b0;
      awaited_results.delete();
      queued = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t unexpected result: expected none actual duty %0d", $time, out_duty_out);
          fails++;
        end else begin
          want = awaited_results.pop_front();
          check_field("duty_out", want.duty, out_duty_out);
          check_field("volt_level", want.volt_level, out_volt_level);
          check_field("curr_level", want.curr_level, out_curr_level);
          check_field("cc_mode", want.cc_mode, out_cc_mode);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_VOLT_GAIN:   regs.volt_gain   = cfg_data[7:0];
          REG_CURR_GAIN:   regs.curr_gain   = cfg_data[7:0];
          REG_VOLT_TARGET: regs.volt_target = cfg_data;
          REG_CURR_TARGET: regs.curr_target = cfg_data;
          REG_DUTY_FLOOR:  regs.duty_floor  = cfg_data;
          REG_DUTY_PERIOD: regs.duty_period = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) awaited_results.push_back(regulate(in_volt_sum, in_curr_sum));
      queued = awaited_results.size();
    end
  end

endmodule

// ----- dv/cc_cv_duty_regulator_tb.sv -----
module cc_cv_duty_regulator_tb;
  import ccr_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
  localparam int QUIET_LIMIT = 5000;
  localparam int FIXED_SETS  = 5;
  localparam int RANDOM_SETS = 9;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [15:0]           in_volt_sum = '0;
  logic [15:0]           in_curr_sum = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [9:0]            out_duty_out;
  logic [9:0]            out_volt_level;
  logic [9:0]            out_curr_level;
  logic                  out_cc_mode;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int   fail_count;
  int   awaiting;
  int   in_idle_pct = 34;
  int   out_idle_pct = 34;
  int   quiet_cycles = 0;
  cfg_t cur;

  cc_cv_duty_regulator dut (.*);

  cc_cv_duty_regulator_checker checker_i (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(negedge clk) out_ready <= ($urandom_range(99) >= out_idle_pct);

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL cc_cv_duty_regulator");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // sum whose scaled level lands near the requested one
  function automatic logic [15:0] sum_near(input int level, input int denom, input int lsb);
    int raw;
    raw = ((level < 0) ? 0 : level) * 256 / denom;
    if (raw > (32'hFFFF >> lsb)) raw = 32'hFFFF >> lsb;
    return 16'((raw << lsb) | ($urandom() & ((1 << lsb) - 1)));
  endfunction

  task automatic send_item(input logic [15:0] vs, input logic [15:0] cs);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_volt_sum <= vs;
    in_curr_sum <= cs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    do @(negedge clk); while (awaiting != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic program_regs(input cfg_t c);
    write_reg(REG_VOLT_GAIN, CFG_DATA_W'(c.volt_gain));
    write_reg(REG_CURR_GAIN, CFG_DATA_W'(c.curr_gain));
    write_reg(REG_VOLT_TARGET, c.volt_target);
    write_reg(REG_CURR_TARGET, c.curr_target);
    write_reg(REG_DUTY_FLOOR, c.duty_floor);
    write_reg(REG_DUTY_PERIOD, c.duty_period);
    write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, CFG_DATA_W'($urandom()));
    cfg_valid <= 1'b0;
    cur = c;
  endtask

  task automatic run_items(input int count);
    int          sel, vlev, clev;
    logic [15:0] vs, cs;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      if (sel < 15) begin
        vs = 16'($urandom());
        cs = 16'($urandom());
      end else begin
        if (sel < 30) vlev = int'(cur.volt_target) + int'($urandom_range(300)) - 150;
        else vlev = int'(cur.volt_target) + int'($urandom_range(40)) - 20;
        sel = $urandom_range(99);
        if (sel < 10) clev = int'($urandom_range(29));
        else if (sel < 30) clev = int'(cur.curr_target) + int'($urandom_range(60, 5));
        else clev = int'(cur.curr_target) + int'($urandom_range(20)) - 10;
        vs = sum_near(vlev, 256 + int'(cur.volt_gain), 7);
        cs = sum_near(clev, 384 + int'(cur.curr_gain), 8);
      end
      send_item(vs, cs);
      if ($urandom_range(99) == 0) drain();
    end
  endtask

  initial begin
    cfg_t fixed_sets[FIXED_SETS];
    cfg_t c;
    logic [15:0] dir_volt[9];
    logic [15:0] dir_curr[9];
    int          vofs[9];
    int          cofs[9];

    fixed_sets[0] = '{8'd0, 8'd0, 10'd0, 10'd0, 10'd0, 10'd0};
    fixed_sets[1] = '{8'd255, 8'd255, 10'd1023, 10'd1023, 10'd1023, 10'd1023};
    fixed_sets[2] = '{8'd180, 8'd120, 10'd400, 10'd100, 10'd700, 10'd300};
    fixed_sets[3] = '{8'd100, 8'd10, 10'd1000, 10'd200, 10'd0, 10'd6};
    fixed_sets[4] = '{8'd128, 8'd64, 10'd1, 10'd1, 10'd10, 10'd900};
    dir_volt = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h8000,
                 16'h7FFF, 16'h5555, 16'hAAAA, 16'h007F};
    dir_curr = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h8000,
                 16'h7FFF, 16'hAAAA, 16'h5555, 16'h00FF};
    vofs = '{-20, -3, 3, 20, 0, 0, -10, 10, 0};
    cofs = '{0, 0, 0, 0, 10, 6, -10, -40, -3};

    cur = '{RST_VOLT_GAIN, RST_CURR_GAIN, RST_VOLT_TARGET,
            RST_CURR_TARGET, RST_DUTY_FLOOR, RST_DUTY_PERIOD};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // field extremes, then steps either side of the targets at reset settings
    for (int i = 0; i < 9; i++) send_item(dir_volt[i], dir_curr[i]);
    for (int i = 0; i < 9; i++)
      send_item(sum_near(int'(cur.volt_target) + vofs[i], 256 + int'(cur.volt_gain), 7),
                sum_near(int'(cur.curr_target) + cofs[i], 384 + int'(cur.curr_gain), 8));

    for (int p = 0; p < FIXED_SETS + RANDOM_SETS; p++) begin
      drain();
      if (p < FIXED_SETS) begin
        c = fixed_sets[p];
      end else begin
        c.volt_gain   = 8'($urandom_range(240, 100));
        c.curr_gain   = 8'($urandom_range(250, 10));
        c.volt_target = 10'($urandom_range(999, 2));
        c.curr_target = 10'($urandom_range(500, 2));
        c.duty_period = 10'($urandom_range(1023, 100));
        if ($urandom_range(4) == 0) c.duty_floor = 10'($urandom());
        else c.duty_floor = 10'($urandom_range(c.duty_period));
      end
      program_regs(c);
      in_idle_pct  = (p == 6) ? 0 : 34;
      out_idle_pct = (p == 6) ? 0 : 34;
      run_items((p < FIXED_SETS) ? 90 : 120);
    end

    drain();
    repeat (16) @(posedge clk);
    if (fail_count == 0 && awaiting == 0) begin
      $display("PASS cc_cv_duty_regulator");
    end else begin
      $display("FAIL cc_cv_duty_regulator");
    end
    $finish;
  end

endmodule
